/* rtl/core/lr_pkg.sv */
// Shared types and constants for the line rasterizer.
package lr_pkg;

  // Default screen geometry
  localparam int unsigned SCREEN_COLUMNS_DEF = 320;
  localparam int unsigned SCREEN_ROWS_DEF    = 200;

  // Field widths
  localparam int unsigned X_W    = 9;
  localparam int unsigned Y_W    = 8;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned COLOR_W = 8;
  // Decision and increment terms: bounded by +-2*511 for 9 and 8 bit coordinates
  localparam int unsigned DEC_W  = 12;

  // Command queue between front and back end
  localparam int unsigned QUEUE_DEPTH = 2;

  // Request codes
  typedef enum logic [0:0] {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  // Input request
  typedef struct packed {
    logic [0:0]         req_type;
    logic [X_W-1:0]     x_start;
    logic [Y_W-1:0]     y_start;
    logic [X_W-1:0]     x_end;
    logic [Y_W-1:0]     y_end;
    logic [COLOR_W-1:0] line_color;
  } req_t;

  // Emitted pixel
  typedef struct packed {
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [ADDR_W-1:0]  pixel_addr;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pix_t;

  // Classified command, carried from front end to back end
  typedef struct packed {
    logic                    is_start;
    logic [X_W-1:0]          cur_x;
    logic [Y_W-1:0]          cur_y;
    logic [X_W-1:0]          goal_x;
    logic [Y_W-1:0]          goal_y;
    logic [ADDR_W-1:0]       addr;
    logic [COLOR_W-1:0]      color;
    logic                    x_major;
    logic                    step_x_neg;
    logic                    step_y_neg;
    logic signed [DEC_W-1:0] decision;
    logic signed [DEC_W-1:0] straight_inc;
    logic signed [DEC_W-1:0] diagonal_inc;
  } cmd_t;

  // Queue status seen by the front and back ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/core/lr_front.sv */
// Front end: accepts requests, clamps endpoints and sets up the line parameters.
module lr_front #(
  parameter int unsigned SCREEN_COLUMNS = lr_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = lr_pkg::SCREEN_ROWS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lr_pkg::req_t   in_data_i,
  input  logic           q_full_i,
  output logic           push_o,
  output lr_pkg::cmd_t   push_data_o
);

  localparam logic [lr_pkg::X_W-1:0]    X_MAX  = lr_pkg::X_W'(SCREEN_COLUMNS - 1);
  localparam logic [lr_pkg::Y_W-1:0]    Y_MAX  = lr_pkg::Y_W'(SCREEN_ROWS - 1);
  localparam logic [lr_pkg::ADDR_W-1:0] STRIDE = lr_pkg::ADDR_W'(SCREEN_COLUMNS);

  logic                       valid_q;
  lr_pkg::cmd_t               cmd_q, cmd_d;
  logic                       advance;

  logic [lr_pkg::X_W-1:0]     cx, gx, adx;
  logic [lr_pkg::Y_W-1:0]     cy, gy, ady;
  logic                       x_gt, y_gt, x_major;
  logic signed [lr_pkg::DEC_W-1:0] maj, mnr;

  // Stage moves whenever it is empty or the queue takes its command
  assign advance    = !valid_q || !q_full_i;
  assign in_stall_o = !advance;
  assign push_o      = valid_q && !q_full_i;
  assign push_data_o = cmd_q;

  // Clamp endpoints to the screen
  always_comb begin
    cx = (int'(in_data_i.x_start) >= int'(SCREEN_COLUMNS)) ? X_MAX : in_data_i.x_start;
    gx = (int'(in_data_i.x_end)   >= int'(SCREEN_COLUMNS)) ? X_MAX : in_data_i.x_end;
    cy = (int'(in_data_i.y_start) >= int'(SCREEN_ROWS))    ? Y_MAX : in_data_i.y_start;
    gy = (int'(in_data_i.y_end)   >= int'(SCREEN_ROWS))    ? Y_MAX : in_data_i.y_end;
  end

  // Deltas, direction and major axis
  always_comb begin
    x_gt    = gx > cx;
    y_gt    = gy > cy;
    adx     = x_gt ? (gx - cx) : (cx - gx);
    ady     = y_gt ? (gy - cy) : (cy - gy);
    x_major = adx > {1'b0, ady};
    if (x_major) begin
      maj = $signed(lr_pkg::DEC_W'(adx));
      mnr = $signed(lr_pkg::DEC_W'(ady));
    end else begin
      maj = $signed(lr_pkg::DEC_W'(ady));
      mnr = $signed(lr_pkg::DEC_W'(adx));
    end
  end

  // Command build
  always_comb begin
    cmd_d              = cmd_q;
    cmd_d.is_start     = (in_data_i.req_type == lr_pkg::REQ_START);
    cmd_d.cur_x        = cx;
    cmd_d.cur_y        = cy;
    cmd_d.goal_x       = gx;
    cmd_d.goal_y       = gy;
    cmd_d.addr         = lr_pkg::ADDR_W'(STRIDE * lr_pkg::ADDR_W'(cy))
                         + lr_pkg::ADDR_W'(cx);
    cmd_d.color        = in_data_i.line_color;
    cmd_d.x_major      = x_major;
    cmd_d.step_x_neg   = !x_gt;
    cmd_d.step_y_neg   = !y_gt;
    cmd_d.straight_inc = mnr <<< 1;
    cmd_d.diagonal_inc = (mnr - maj) <<< 1;
    cmd_d.decision     = (mnr <<< 1) - maj;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

/* rtl/core/lr_queue.sv */
// Short command queue between the front end and the back end.
module lr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lr_pkg::cmd_t      push_data_i,
  input  logic              pop_i,
  output lr_pkg::cmd_t      pop_data_o,
  output lr_pkg::q_status_t status_o
);

  localparam int unsigned DEPTH = lr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lr_pkg::cmd_t     entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == FULL_CNT);
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign pop_data_o     = entry_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* rtl/core/lr_back.sv */
// Back end: Bresenham stepping state and the registered pixel output.
module lr_back #(
  parameter int unsigned SCREEN_COLUMNS = lr_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = lr_pkg::SCREEN_ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lr_pkg::q_status_t q_status_i,
  input  lr_pkg::cmd_t      cmd_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lr_pkg::pix_t      out_data_o
);

  localparam logic [lr_pkg::ADDR_W-1:0] STRIDE = lr_pkg::ADDR_W'(SCREEN_COLUMNS);

  // Line state
  logic                            busy_q, busy_d;
  logic [lr_pkg::X_W-1:0]          cur_x_q, cur_x_d, goal_x_q, goal_x_d;
  logic [lr_pkg::Y_W-1:0]          cur_y_q, cur_y_d, goal_y_q, goal_y_d;
  logic [lr_pkg::ADDR_W-1:0]       addr_q, addr_d;
  logic [lr_pkg::COLOR_W-1:0]      color_q, color_d;
  logic signed [lr_pkg::DEC_W-1:0] dec_q, dec_d, sinc_q, sinc_d, dinc_q, dinc_d;
  logic                            x_major_q, x_major_d;
  logic                            sxn_q, sxn_d, syn_q, syn_d;

  logic                            out_valid_q, out_valid_d;
  lr_pkg::pix_t                    out_q, out_d;

  logic                            can_load, emit;
  logic                            diag, move_x, move_y;
  logic [lr_pkg::X_W-1:0]          step_x;
  logic [lr_pkg::Y_W-1:0]          step_y;
  logic [lr_pkg::ADDR_W-1:0]       dx_addr, dy_addr;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign pop_o       = !q_status_i.empty && can_load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // One midpoint step from the current state
  always_comb begin
    diag    = dec_q > 0;
    move_x  = x_major_q || diag;
    move_y  = !x_major_q || diag;
    step_x  = sxn_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
    step_y  = syn_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
    dx_addr = !move_x ? '0 : (sxn_q ? '1 : lr_pkg::ADDR_W'(1));
    dy_addr = !move_y ? '0 : (syn_q ? (~STRIDE + 1'b1) : STRIDE);
  end

  // Next state and output
  always_comb begin
    busy_d    = busy_q;
    cur_x_d   = cur_x_q;
    cur_y_d   = cur_y_q;
    goal_x_d  = goal_x_q;
    goal_y_d  = goal_y_q;
    addr_d    = addr_q;
    color_d   = color_q;
    dec_d     = dec_q;
    sinc_d    = sinc_q;
    dinc_d    = dinc_q;
    x_major_d = x_major_q;
    sxn_d     = sxn_q;
    syn_d     = syn_q;
    emit      = 1'b0;

    if (pop_o) begin
      if (cmd_i.is_start) begin
        emit      = 1'b1;
        cur_x_d   = cmd_i.cur_x;
        cur_y_d   = cmd_i.cur_y;
        goal_x_d  = cmd_i.goal_x;
        goal_y_d  = cmd_i.goal_y;
        addr_d    = cmd_i.addr;
        color_d   = cmd_i.color;
        dec_d     = cmd_i.decision;
        sinc_d    = cmd_i.straight_inc;
        dinc_d    = cmd_i.diagonal_inc;
        x_major_d = cmd_i.x_major;
        sxn_d     = cmd_i.step_x_neg;
        syn_d     = cmd_i.step_y_neg;
      end else if (busy_q) begin
        // tick while idle leaves everything alone
        emit    = 1'b1;
        dec_d   = dec_q + (diag ? dinc_q : sinc_q);
        cur_x_d = move_x ? step_x : cur_x_q;
        cur_y_d = move_y ? step_y : cur_y_q;
        addr_d  = addr_q + dx_addr + dy_addr;
      end
      busy_d = x_major_d ? (cur_x_d != goal_x_d) : (cur_y_d != goal_y_d);
      if (!emit) begin
        busy_d = busy_q;
      end
    end

    out_d.pixel_x     = cur_x_d;
    out_d.pixel_y     = cur_y_d;
    out_d.pixel_addr  = addr_d;
    out_d.pixel_color = color_d;
    out_d.last_pixel  = !busy_d;

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      x_major_q   <= 1'b0;
      sxn_q       <= 1'b0;
      syn_q       <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      goal_x_q    <= '0;
      goal_y_q    <= '0;
      addr_q      <= '0;
      dec_q       <= '0;
      sinc_q      <= '0;
      dinc_q      <= '0;
      color_q     <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      x_major_q   <= x_major_d;
      sxn_q       <= sxn_d;
      syn_q       <= syn_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      goal_x_q    <= goal_x_d;
      goal_y_q    <= goal_y_d;
      addr_q      <= addr_d;
      dec_q       <= dec_d;
      sinc_q      <= sinc_d;
      dinc_q      <= dinc_d;
      color_q     <= color_d;
    end
  end

  // Output pixel register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  // A busy engine has not reached its goal on the major axis
  a_busy_goal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (x_major_q ? (cur_x_q != goal_x_q) : (cur_y_q != goal_y_q)))
    else $error("busy with major axis at goal");

  // The pending pixel's last flag agrees with the engine state
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last_pixel == !busy_q))
    else $error("last flag disagrees with busy");

  // The incrementally tracked address matches the coordinates
  a_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.pixel_addr == lr_pkg::ADDR_W'(
      STRIDE * lr_pkg::ADDR_W'(out_q.pixel_y)) + lr_pkg::ADDR_W'(out_q.pixel_x)))
    else $error("pixel address does not match coordinates");

  // Emitted pixels stay on screen
  a_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (int'(out_q.pixel_x) < int'(SCREEN_COLUMNS) &&
                     int'(out_q.pixel_y) < int'(SCREEN_ROWS)))
    else $error("pixel off screen");

  // A start request always produces a pixel on the next cycle
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cmd_i.is_start) |=> out_valid_q)
    else $error("start request produced no pixel");

endmodule

/* rtl/core/line_rasterizer_unit.sv */
// Line rasterizer top level: front end, command queue and stepping back end.
//
// Bresenham line engine for a byte-per-pixel frame buffer of SCREEN_COLUMNS by
// SCREEN_ROWS pixels. A start request (endpoints clamped to the screen) emits the
// first pixel; each tick request emits the next pixel with its coordinates,
// frame buffer address (columns * row + column) and color, the final one flagged
// last. A tick while no line is active yields nothing; a start replaces any line
// in progress. One request is taken and one pixel delivered per clock when the
// output is not stalled; a request's pixel is registered in the front setup
// register, a command queue entry and the pixel output register, in that order.
// The back end's decision loop sets the rate, one step per cycle unless stalled.
module line_rasterizer_unit #(
  parameter int unsigned SCREEN_COLUMNS = lr_pkg::SCREEN_COLUMNS_DEF,
  parameter int unsigned SCREEN_ROWS    = lr_pkg::SCREEN_ROWS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  lr_pkg::req_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output lr_pkg::pix_t out_data_o
);

  logic              push, pop;
  lr_pkg::cmd_t      push_cmd, pop_cmd;
  lr_pkg::q_status_t q_status;

  lr_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_status.full),
    .push_o     (push),
    .push_data_o(push_cmd)
  );

  lr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_cmd),
    .pop_i      (pop),
    .pop_data_o (pop_cmd),
    .status_o   (q_status)
  );

  lr_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_status_i (q_status),
    .cmd_i      (pop_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
